// File: rtl/mmcal_pkg.sv
// ----------------------------------------------------------------------------
// mmcal_pkg
// Shared types and constants of the min/max magnetometer calibration block.
// ----------------------------------------------------------------------------
package mmcal_pkg;

  localparam int SAMPLE_BITS     = 16;
  localparam int SLOPE_FRAC_BITS = 16;
  localparam int SLOPE_INT_BITS  = 8;
  localparam int SLOPE_BITS      = SLOPE_INT_BITS + SLOPE_FRAC_BITS;
  localparam int FI_BITS         = 15;
  // numerator of the slope: 2 * field_intensity, shifted up by the fraction
  localparam int NUM_BITS        = FI_BITS + 1 + SLOPE_FRAC_BITS;
  localparam int NUM_AXES        = 3;
  localparam int AXIS_BITS       = $clog2(NUM_AXES);

  localparam logic [FI_BITS-1:0] FI_RESET = FI_BITS'(3571);

  // command codes
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_SAMPLE = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;

  // configuration port
  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 3;
  localparam logic [0:0] REG_FIELD_INTENSITY = 1'b0;

  typedef struct packed {
    logic [1:0]                    cmd;
    logic signed [SAMPLE_BITS-1:0] sample_x;
    logic signed [SAMPLE_BITS-1:0] sample_y;
    logic signed [SAMPLE_BITS-1:0] sample_z;
  } mmcal_in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] offset_x;
    logic signed [SAMPLE_BITS-1:0] offset_y;
    logic signed [SAMPLE_BITS-1:0] offset_z;
    logic [SLOPE_BITS-1:0]         slope_x;
    logic [SLOPE_BITS-1:0]         slope_y;
    logic [SLOPE_BITS-1:0]         slope_z;
    logic                          calib_error;
  } mmcal_out_t;

endpackage

// File: rtl/magnetometer_min_max_calibration_top.sv
// ----------------------------------------------------------------------------
// magnetometer_min_max_calibration_top
// Per-axis min/max tracking with hard-iron offset and scale factor report.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                   | transaction
//  in      | input     | in_valid_i / in_stall_o     | command and xyz sample
//  out     | output    | out_valid_o / out_stall_i   | offsets, slopes, error
//  cfg     | input     | psel/penable/pwrite, pready | field_intensity register
//
//  Clear and sample commands are applied when accepted. A finish command with
//  no sample or a zero range reports in the cycle after it is accepted;
//  otherwise one restoring divider, one quotient bit a cycle, serves the three
//  axes in turn before the result is registered. The input stalls while
//  dividing, and a finish command also stalls while an earlier result is
//  still held. Reset clears the trackers and loads field_intensity with 3571.
// ----------------------------------------------------------------------------
module magnetometer_min_max_calibration_top (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      in_valid_i,
  output logic                                      in_stall_o,
  input  mmcal_pkg::mmcal_in_t                      in_data_i,
  output logic                                      out_valid_o,
  input  logic                                      out_stall_i,
  output mmcal_pkg::mmcal_out_t                     out_data_o,
  input  logic                                      psel,
  input  logic                                      penable,
  input  logic                                      pwrite,
  input  logic [mmcal_pkg::APB_ADDR_BITS-1:0]       paddr,
  input  logic [mmcal_pkg::APB_DATA_BITS-1:0]       pwdata,
  output logic [mmcal_pkg::APB_DATA_BITS-1:0]       prdata,
  output logic                                      pready
);
  import mmcal_pkg::*;

  localparam int CNT_BITS = $clog2(NUM_BITS);
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [AXIS_BITS-1:0] LAST_AXIS = AXIS_BITS'(NUM_AXES - 1);
  localparam logic [CNT_BITS-1:0]  LAST_BIT  = CNT_BITS'(NUM_BITS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV
  } state_e;

  state_e                        state_q;
  logic [AXIS_BITS-1:0]          axis_q;
  logic [CNT_BITS-1:0]           cnt_q;
  logic                          seen_q;
  logic                          out_valid_q;
  logic [FI_BITS-1:0]            fi_q;
  logic signed [SAMPLE_BITS-1:0] max_q [NUM_AXES];
  logic signed [SAMPLE_BITS-1:0] min_q [NUM_AXES];

  logic [SAMPLE_BITS-1:0]        divisor_q;
  logic [SAMPLE_BITS-1:0]        rem_q;
  logic [NUM_BITS-1:0]           quo_q;
  mmcal_out_t                    out_q;

  logic                          in_accept;
  logic                          out_take;
  logic                          cfg_write;
  logic                          last_bit;
  logic                          zero_rng;
  logic signed [SAMPLE_BITS-1:0] smp [NUM_AXES];
  logic signed [SAMPLE_BITS-1:0] mid [NUM_AXES];
  logic signed [SAMPLE_BITS:0]   sum [NUM_AXES];
  logic [SAMPLE_BITS-1:0]        range_sel;
  logic [SAMPLE_BITS:0]          trial;
  logic                          ge;
  logic [SAMPLE_BITS-1:0]        rem_d;
  logic [NUM_BITS-1:0]           quo_d;
  logic [SLOPE_BITS-1:0]         slope_d;
  logic [NUM_BITS-1:0]           numerator;

  // --------------------------------------------------------------------------
  // handshakes and configuration port
  // --------------------------------------------------------------------------
  assign in_stall_o  = (state_q != ST_IDLE) || (out_valid_q && in_data_i.cmd == CMD_FINISH);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_take    = out_valid_q && !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr[APB_ADDR_BITS-1:2] == REG_FIELD_INTENSITY);
  assign prdata    = (paddr[APB_ADDR_BITS-1:2] == REG_FIELD_INTENSITY) ?
                     APB_DATA_BITS'(fi_q) : '0;

  // --------------------------------------------------------------------------
  // trackers, offsets and the shared divider step
  // --------------------------------------------------------------------------
  assign smp[0] = in_data_i.sample_x;
  assign smp[1] = in_data_i.sample_y;
  assign smp[2] = in_data_i.sample_z;

  always_comb begin
    zero_rng = 1'b0;
    for (int i = 0; i < NUM_AXES; i++) begin
      sum[i]   = {max_q[i][SAMPLE_BITS-1], max_q[i]} + {min_q[i][SAMPLE_BITS-1], min_q[i]};
      // arithmetic shift right by one: drop the low bit
      mid[i]   = sum[i][SAMPLE_BITS:1];
      zero_rng = zero_rng || (max_q[i] == min_q[i]);
    end
  end

  // max >= min once a sample is seen, so the difference fits unsigned
  assign range_sel = SAMPLE_BITS'(max_q[axis_q] - min_q[axis_q]);
  assign numerator = {fi_q, 1'b0, {SLOPE_FRAC_BITS{1'b0}}};

  assign trial    = {rem_q, quo_q[NUM_BITS-1]};
  assign ge       = trial >= {1'b0, divisor_q};
  assign rem_d    = ge ? SAMPLE_BITS'(trial - {1'b0, divisor_q}) : trial[SAMPLE_BITS-1:0];
  assign quo_d    = {quo_q[NUM_BITS-2:0], ge};
  assign slope_d  = (|quo_d[NUM_BITS-1:SLOPE_BITS]) ? '1 : quo_d[SLOPE_BITS-1:0];
  assign last_bit = (cnt_q == LAST_BIT);

  // --------------------------------------------------------------------------
  // sequencer and control state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= '0;
      cnt_q       <= '0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
      fi_q        <= FI_RESET;
      for (int i = 0; i < NUM_AXES; i++) begin
        max_q[i] <= SAMPLE_MIN;
        min_q[i] <= SAMPLE_MAX;
      end
    end else begin
      if (cfg_write) begin
        fi_q <= pwdata[FI_BITS-1:0];
      end
      if (out_take) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            case (in_data_i.cmd)
              CMD_CLEAR: begin
                seen_q <= 1'b0;
                for (int i = 0; i < NUM_AXES; i++) begin
                  max_q[i] <= SAMPLE_MIN;
                  min_q[i] <= SAMPLE_MAX;
                end
              end
              CMD_SAMPLE: begin
                seen_q <= 1'b1;
                for (int i = 0; i < NUM_AXES; i++) begin
                  if (smp[i] > max_q[i]) max_q[i] <= smp[i];
                  if (smp[i] < min_q[i]) min_q[i] <= smp[i];
                end
              end
              CMD_FINISH: begin
                if (!seen_q || zero_rng) begin
                  out_valid_q <= 1'b1;
                end else begin
                  axis_q  <= '0;
                  state_q <= ST_LOAD;
                end
              end
              default: ;
            endcase
          end
        end
        ST_LOAD: begin
          cnt_q   <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (last_bit) begin
            if (axis_q == LAST_AXIS) begin
              out_valid_q <= 1'b1;
              state_q     <= ST_IDLE;
            end else begin
              axis_q  <= axis_q + 1'b1;
              state_q <= ST_LOAD;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // divider datapath and result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_accept && in_data_i.cmd == CMD_FINISH) begin
          out_q.offset_x    <= seen_q ? mid[0] : '0;
          out_q.offset_y    <= seen_q ? mid[1] : '0;
          out_q.offset_z    <= seen_q ? mid[2] : '0;
          out_q.slope_x     <= '0;
          out_q.slope_y     <= '0;
          out_q.slope_z     <= '0;
          out_q.calib_error <= !seen_q || zero_rng;
        end
      end
      ST_LOAD: begin
        divisor_q <= range_sel;
        rem_q     <= '0;
        quo_q     <= numerator;
      end
      ST_DIV: begin
        rem_q <= rem_d;
        quo_q <= quo_d;
        if (last_bit) begin
          case (axis_q)
            2'd0:    out_q.slope_x <= slope_d;
            2'd1:    out_q.slope_y <= slope_d;
            default: out_q.slope_z <= slope_d;
          endcase
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // the divider never runs over a result that is still held
  a_no_div_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> !out_valid_q)
    else $error("divider active while a result is pending");

  // an error result carries zero slopes
  a_error_zero_slope: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.calib_error) |->
      (out_q.slope_x == '0 && out_q.slope_y == '0 && out_q.slope_z == '0))
    else $error("error result with nonzero slope");

  // trackers stay ordered once a sample is seen
  a_tracker_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q |-> (max_q[0] >= min_q[0] && max_q[1] >= min_q[1] && max_q[2] >= min_q[2]))
    else $error("tracker max below min");

  // a result appears only after a finish transaction or the last divider step
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(in_accept) || $past(state_q == ST_DIV)))
    else $error("result raised without a source");

endmodule
